// ----- hdl/lfr_pkg.sv -----
// Shared types and constants for the LED frame run-length decoder.
// Depends on nothing; every other file of the block but lfr_div uses it.
`default_nettype none

package lfr_pkg;

   // Record modes held in the encoding register; the unused code decodes as rgb24.
   localparam logic [1:0] ENC_RGB24   = 2'd0;
   localparam logic [1:0] ENC_565_RAW = 2'd1;
   localparam logic [1:0] ENC_565_RLE = 2'd2;

   // RGB565 field masks
   localparam logic [7:0] HI_RED_MASK   = 8'hF8;
   localparam logic [7:0] HI_GREEN_MASK = 8'h07;
   localparam logic [7:0] LO_GREEN_MASK = 8'hE0;
   localparam logic [7:0] LO_BLUE_MASK  = 8'h1F;

   // Register reset values
   localparam logic [1:0]  ENCODING_RST    = ENC_RGB24;
   localparam logic [10:0] LED_COUNT_RST   = 11'd64;
   localparam logic [10:0] LED_COLUMNS_RST = 11'd8;
   localparam logic [15:0] FRAME_COUNT_RST = 16'd1;

   localparam logic [10:0] MAX_COLUMNS = 11'd1024;

   // Shared divider: wide enough for the frame counter plus one
   localparam int DIV_W = 17;

   typedef enum logic [1:0] {
      CSR_ENCODING    = 2'd0,
      CSR_LED_COUNT   = 2'd1,
      CSR_LED_COLUMNS = 2'd2,
      CSR_FRAME_COUNT = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [7:0] byte0;
      logic [7:0] byte1;
      logic [7:0] byte2;
   } req_type;

   typedef struct packed {
      logic [9:0]  start_row;
      logic [9:0]  start_col;
      logic [7:0]  run_count;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
      logic [15:0] frame_number;
      logic        frame_end;
      logic        overrun;
   } rsp_type;

   // Controller to datapath
   typedef struct packed {
      logic load;        // capture the input record
      logic div_pos;     // start the row and column split
      logic emit;        // register the result, advance the position
      logic div_frame;   // start the frame number wrap
      logic frame_load;  // take the wrapped frame number
   } cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic div_busy;
      logic out_free;
      logic frame_wrap;
   } status_type;

endpackage

`default_nettype wire

// ----- hdl/lfr_div.sv -----
// Restoring divider, one quotient bit per cycle.
// Depends on nothing; used by lfr_datapath for row/column split and frame wrap.
`default_nettype none

module lfr_div #(
   parameter int WIDTH = 17
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             start,
   input  wire logic [WIDTH-1:0] dividend,
   input  wire logic [WIDTH-1:0] divisor,
   output logic                  busy,
   output logic      [WIDTH-1:0] quotient,
   output logic      [WIDTH-1:0] remainder
);

   localparam int CNT_W = $clog2(WIDTH + 1);

   logic [WIDTH-1:0] rem_ff, rem_in;
   logic [WIDTH-1:0] quo_ff, quo_in;
   logic [WIDTH-1:0] dvs_ff, dvs_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic [WIDTH:0]   shifted;
   logic [WIDTH:0]   diff;

   always_comb begin
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      shifted = {rem_ff, quo_ff[WIDTH-1]};
      diff    = shifted - {1'b0, dvs_ff};
      if (start) begin
         rem_in  = '0;
         quo_in  = dividend;
         dvs_in  = divisor;
         cnt_in  = CNT_W'(WIDTH);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         // subtract when the divisor fits, else keep the shifted partial remainder
         if (!diff[WIDTH]) begin
            rem_in = diff[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b1};
         end else begin
            rem_in = shifted[WIDTH-1:0];
            quo_in = {quo_ff[WIDTH-2:0], 1'b0};
         end
         cnt_in  = cnt_ff - 1'b1;
         busy_in = (cnt_ff != CNT_W'(1));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
   end

   assign busy      = busy_ff;
   assign quotient  = quo_ff;
   assign remainder = rem_ff;

endmodule

`default_nettype wire

// ----- hdl/lfr_datapath.sv -----
// Datapath of the LED frame decoder: registers, record decode, position and frame tracking.
// Depends on lfr_pkg and lfr_div; driven by commands from lfr_ctrl.
`default_nettype none

module lfr_datapath #(
   parameter int MAX_LEDS = 1024
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire lfr_pkg::req_type      req_data,
   output lfr_pkg::rsp_type           rsp_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   input  wire logic                  csr_valid,
   input  wire lfr_pkg::csr_index_type csr_index,
   input  wire logic [15:0]           csr_wdata,
   input  wire lfr_pkg::cmd_type      cmd,
   output lfr_pkg::status_type        status
);

   import lfr_pkg::*;

   // configuration
   logic [1:0]  encoding_ff, encoding_in;
   logic [10:0] led_count_ff, led_count_in;
   logic [10:0] led_columns_ff, led_columns_in;
   logic [15:0] frame_count_ff, frame_count_in;

   // tracking state
   logic [10:0] pos_ff, pos_in;
   logic [15:0] frame_ff, frame_in;

   // record and result
   req_type     rec_ff, rec_in;
   rsp_type     rsp_ff, rsp_in;
   logic        rsp_valid_ff, rsp_valid_in;

   // decode
   logic [10:0] n_eff;
   logic [10:0] c_eff;
   logic [15:0] fc_eff;
   logic [7:0]  run_raw, run_clip;
   logic [7:0]  hi, lo, red, green, blue;
   logic        is565;
   logic [10:0] remaining;
   logic        over;
   logic [11:0] pos_sum;
   logic        run_end;
   logic [16:0] frame_inc;
   logic        wrap;

   // divider
   logic             div_start;
   logic [DIV_W-1:0] div_dividend, div_divisor, div_quo, div_rem;
   logic             div_busy;

   always_comb begin
      n_eff = led_count_ff;
      if (led_count_ff == 11'd0) begin
         n_eff = 11'd1;
      end else if (32'(led_count_ff) > 32'(MAX_LEDS)) begin
         n_eff = 11'(MAX_LEDS);
      end
      c_eff = led_columns_ff;
      if (led_columns_ff == 11'd0) begin
         c_eff = 11'd1;
      end else if (led_columns_ff > MAX_COLUMNS) begin
         c_eff = MAX_COLUMNS;
      end
      fc_eff = (frame_count_ff == 16'd0) ? 16'd1 : frame_count_ff;
   end

   always_comb begin
      run_raw = 8'd1;
      hi      = rec_ff.byte0;
      lo      = rec_ff.byte1;
      is565   = 1'b1;
      unique case (encoding_ff)
         ENC_565_RAW: begin
            run_raw = 8'd1;
            hi      = rec_ff.byte0;
            lo      = rec_ff.byte1;
         end
         ENC_565_RLE: begin
            run_raw = rec_ff.byte0;
            hi      = rec_ff.byte1;
            lo      = rec_ff.byte2;
         end
         default: begin
            is565 = 1'b0;
         end
      endcase
      if (is565) begin
         red   = hi & HI_RED_MASK;
         green = ((hi & HI_GREEN_MASK) << 5) | ((lo & LO_GREEN_MASK) >> 3);
         blue  = (lo & LO_BLUE_MASK) << 3;
      end else begin
         red   = rec_ff.byte0;
         green = rec_ff.byte1;
         blue  = rec_ff.byte2;
      end

      remaining = (pos_ff < n_eff) ? (n_eff - pos_ff) : 11'd0;
      over      = ({3'd0, run_raw} > remaining);
      run_clip  = over ? remaining[7:0] : run_raw;
      pos_sum   = {1'b0, pos_ff} + {4'd0, run_clip};
      run_end   = (pos_sum >= {1'b0, n_eff});
      frame_inc = {1'b0, frame_ff} + 17'd1;
      wrap      = run_end && (frame_inc >= {1'b0, fc_eff});
   end

   assign div_start    = cmd.div_pos || cmd.div_frame;
   assign div_dividend = cmd.div_frame ? frame_inc : {{(DIV_W-11){1'b0}}, pos_ff};
   assign div_divisor  = cmd.div_frame ? {1'b0, fc_eff} : {{(DIV_W-11){1'b0}}, c_eff};

   lfr_div #(
      .WIDTH(DIV_W)
   ) u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .busy     (div_busy),
      .quotient (div_quo),
      .remainder(div_rem)
   );

   always_comb begin
      encoding_in    = encoding_ff;
      led_count_in   = led_count_ff;
      led_columns_in = led_columns_ff;
      frame_count_in = frame_count_ff;
      if (csr_valid) begin
         unique case (csr_index)
            CSR_ENCODING:    encoding_in    = csr_wdata[1:0];
            CSR_LED_COUNT:   led_count_in   = csr_wdata[10:0];
            CSR_LED_COLUMNS: led_columns_in = csr_wdata[10:0];
            CSR_FRAME_COUNT: frame_count_in = csr_wdata;
            default:         encoding_in    = encoding_ff;
         endcase
      end
   end

   always_comb begin
      rec_in       = cmd.load ? req_data : rec_ff;
      pos_in       = pos_ff;
      frame_in     = frame_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.emit) begin
         // row and column come from the split started at accept
         rsp_in.start_row    = div_quo[9:0];
         rsp_in.start_col    = div_rem[9:0];
         rsp_in.run_count    = run_clip;
         rsp_in.red          = red;
         rsp_in.green        = green;
         rsp_in.blue         = blue;
         rsp_in.frame_number = frame_ff;
         rsp_in.frame_end    = run_end;
         rsp_in.overrun      = over;
         rsp_valid_in        = 1'b1;
         pos_in              = run_end ? 11'd0 : pos_sum[10:0];
         if (run_end && !wrap) begin
            frame_in = frame_inc[15:0];
         end
      end
      if (cmd.frame_load) begin
         frame_in = div_rem[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         encoding_ff    <= ENCODING_RST;
         led_count_ff   <= LED_COUNT_RST;
         led_columns_ff <= LED_COLUMNS_RST;
         frame_count_ff <= FRAME_COUNT_RST;
         pos_ff         <= '0;
         frame_ff       <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         encoding_ff    <= encoding_in;
         led_count_ff   <= led_count_in;
         led_columns_ff <= led_columns_in;
         frame_count_ff <= frame_count_in;
         pos_ff         <= pos_in;
         frame_ff       <= frame_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      rec_ff <= rec_in;
      rsp_ff <= rsp_in;
   end

   assign rsp_data          = rsp_ff;
   assign rsp_valid         = rsp_valid_ff;
   assign status.div_busy   = div_busy;
   assign status.out_free   = !rsp_valid_ff || rsp_ready;
   assign status.frame_wrap = wrap;

endmodule

`default_nettype wire

// ----- hdl/lfr_ctrl.sv -----
// Controller of the LED frame decoder: sequences accept, split, emit and frame wrap.
// Depends on lfr_pkg; drives lfr_datapath by command and reads its status.
`default_nettype none

module lfr_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     req_ready,
   input  wire lfr_pkg::status_type status,
   output lfr_pkg::cmd_type         cmd
);

   import lfr_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_POS_DIV,
      ST_EMIT,
      ST_FRAME_DIV
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load    = 1'b1;
               cmd.div_pos = 1'b1;
               state_in    = ST_POS_DIV;
            end
         end
         ST_POS_DIV: begin
            if (!status.div_busy) begin
               state_in = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (status.out_free) begin
               cmd.emit = 1'b1;
               if (status.frame_wrap) begin
                  cmd.div_frame = 1'b1;
                  state_in      = ST_FRAME_DIV;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_FRAME_DIV: begin
            if (!status.div_busy) begin
               cmd.frame_load = 1'b1;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

`default_nettype wire

// ----- hdl/led_frame_rle_rgb565_decoder.sv -----
// Top level of the LED frame run-length decoder.
// Depends on lfr_pkg, lfr_ctrl, lfr_datapath (and lfr_div below it).
//
// Usage:
//   req_*  : one three-byte record per transfer (rgb24 raw, rgb565 raw or
//            rgb565 run-length, selected by the encoding register).
//   rsp_*  : one result per record: start row/column of the run, clipped
//            run length, 8-bit colour, frame number, frame end, overrun.
//   csr_*  : register writes, index 0 encoding, 1 led_count, 2 led_columns,
//            3 frame_count; always ready. Write only while the block is idle.
//   Path: a record transfer starts the row/column split, and the result is
//   registered at its emit step; the split runs on a 17-bit restoring
//   divider, one quotient bit per cycle. Records are taken one at a time,
//   the next only after the last is emitted; a record that ends the frame
//   and wraps the frame number runs the divider again for the modulo first.
//   Reset: registers return to their defaults, position and frame go to 0.
//   Stall: a result waits in the output register while rsp_ready is low;
//   the next record is accepted meanwhile and is held at its emit step.
`default_nettype none

module led_frame_rle_rgb565_decoder #(
   parameter int MAX_LEDS = 1024
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire lfr_pkg::req_type       req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output lfr_pkg::rsp_type            rsp_data,
   input  wire logic                   csr_valid,
   output logic                        csr_ready,
   input  wire lfr_pkg::csr_index_type csr_index,
   input  wire logic [15:0]            csr_wdata
);

   import lfr_pkg::*;

   cmd_type    cmd;
   status_type status;

   // registers take a write in any cycle
   assign csr_ready = 1'b1;

   lfr_ctrl u_ctrl (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .status   (status),
      .cmd      (cmd)
   );

   lfr_datapath #(
      .MAX_LEDS(MAX_LEDS)
   ) u_dp (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_data),
      .rsp_data (rsp_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .csr_valid(csr_valid && csr_ready),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata),
      .cmd      (cmd),
      .status   (status)
   );

endmodule

`default_nettype wire

// ----- hdl/lfr_checker.sv -----
// Port-level checks for the LED frame decoder, bound to the top level.
// Depends on lfr_pkg and led_frame_rle_rgb565_decoder.
`default_nettype none

module lfr_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire lfr_pkg::rsp_type rsp_data
);

   // a stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result dropped or changed");

   // nothing shows right after reset
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a clipped run always closes the frame
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.overrun |-> rsp_data.frame_end)
      else $error("overrun without frame end");

   // one record at a time: busy right after a transfer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("record taken while one is in work");

   // a record transfer never produces a result in the next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !rsp_valid |=> !rsp_valid)
      else $error("result appeared too early");

endmodule

bind led_frame_rle_rgb565_decoder lfr_checker u_lfr_checker (.*);

`default_nettype wire

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// Self-checking bench for led_frame_rle_rgb565_decoder: directed records, then random record
// streams under changing register settings, every result checked against a local predictor.
// Depends on lfr_pkg and the decoder RTL.

module tb;
   import lfr_pkg::*;

   localparam int MaxLeds = 1024;
   // The block keeps working after its last result when a frame wraps, while the frame number modulo runs.
   localparam int SettleCycles = 48;
   localparam int SegmentRecords = 110;
   localparam int SegmentsPerPhase = 6;
   // Spare encoding code, decoded like rgb24 raw
   localparam logic [1:0] EncUnused = 2'd3;

   logic          clock;
   logic          reset;
   logic          req_valid;
   logic          req_ready;
   req_type       req_data;
   logic          rsp_valid;
   logic          rsp_ready = 1'b0;
   rsp_type       rsp_data;
   logic          csr_valid;
   logic          csr_ready;
   csr_index_type csr_index;
   logic [15:0]   csr_wdata;

   // Predictor copy of the registers and of the frame state
   int unsigned enc_q, count_q, cols_q, frames_q;
   int unsigned led_pos, frame_q;

   rsp_type     expected_runs[$];
   int unsigned req_idle_pct, rsp_stall_pct;
   int          errors;

   led_frame_rle_rgb565_decoder #(.MAX_LEDS(MaxLeds)) dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   // Hard stop in case a handshake never completes.
   initial begin
      #20_000_000;
      $display("tb: FAIL");
      $finish;
   end

   // Work out the run one record paints, then advance position and frame number.
   function automatic rsp_type predict_run(req_type rec);
      int unsigned n, cols, fc, run, remaining;
      logic [7:0]  hi, lo;
      rsp_type     e;
      // Clamp the geometry: zero counts act as one, oversize counts saturate.
      n = (count_q == 0) ? 1 : count_q;
      if (n > MaxLeds) n = MaxLeds;
      cols = (cols_q == 0) ? 1 : cols_q;
      if (cols > 1024) cols = 1024;
      fc = (frames_q == 0) ? 1 : frames_q;
      e = '0;
      if (enc_q == ENC_565_RAW || enc_q == ENC_565_RLE) begin
         if (enc_q == ENC_565_RLE) begin
            run = rec.byte0;
            hi  = rec.byte1;
            lo  = rec.byte2;
         end else begin
            run = 1;
            hi  = rec.byte0;
            lo  = rec.byte1;
         end
         // Expand 5-6-5 to 8 bits per channel, low bits left at zero.
         e.red   = hi & HI_RED_MASK;
         e.green = ((hi & HI_GREEN_MASK) << 5) | ((lo & LO_GREEN_MASK) >> 3);
         e.blue  = (lo & LO_BLUE_MASK) << 3;
      end else begin
         // rgb24 raw, and the unused encoding code decodes the same way
         run     = 1;
         e.red   = rec.byte0;
         e.green = rec.byte1;
         e.blue  = rec.byte2;
      end
      // Clip the run to the LEDs left; none are left once the position is past the count.
      remaining = (led_pos < n) ? n - led_pos : 0;
      e.overrun = run > remaining;
      if (e.overrun) run = remaining;
      e.start_row    = 10'(led_pos / cols);
      e.start_col    = 10'(led_pos % cols);
      e.run_count    = 8'(run);
      e.frame_number = 16'(frame_q);
      e.frame_end    = (led_pos + run) >= n;
      if (e.frame_end) begin
         led_pos = 0;
         frame_q = (frame_q + 1) % fc;
      end else begin
         led_pos = (led_pos + run) & 32'h7FF;
      end
      return e;
   endfunction

   function automatic void check_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want, got);
         errors++;
      end
   endfunction

   // Take each result transfer, compare it with the oldest prediction, then pick
   // the next ready level according to the current stall rate.
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_runs.size() == 0) begin
            $display("%0t: unexpected result, expected none actual %p", $time, rsp_data);
            errors++;
         end else begin
            want = expected_runs.pop_front();
            check_field("start_row", want.start_row, rsp_data.start_row);
            check_field("start_col", want.start_col, rsp_data.start_col);
            check_field("run_count", want.run_count, rsp_data.run_count);
            check_field("red", want.red, rsp_data.red);
            check_field("green", want.green, rsp_data.green);
            check_field("blue", want.blue, rsp_data.blue);
            check_field("frame_number", want.frame_number, rsp_data.frame_number);
            check_field("frame_end", want.frame_end, rsp_data.frame_end);
            check_field("overrun", want.overrun, rsp_data.overrun);
         end
      end
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // Send one record: idle at random first, then hold valid until the transfer.
   // Valid stays high on return so back-to-back records need no drop.
   task automatic send_record(input req_type rec);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= rec;
      expected_runs.push_back(predict_run(rec));
      do @(posedge clock); while (!req_ready);
   endtask

   task automatic send_bytes(input logic [7:0] b0, input logic [7:0] b1, input logic [7:0] b2);
      req_type rec;
      rec.byte0 = b0;
      rec.byte1 = b1;
      rec.byte2 = b2;
      send_record(rec);
   endtask

   // Drop valid, drain every pending result, then let the frame-wrap tail finish.
   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_runs.size() != 0) @(posedge clock);
      repeat (SettleCycles) @(posedge clock);
   endtask

   task automatic write_csr(input csr_index_type idx, input int unsigned value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= 16'(value);
      do @(posedge clock); while (!csr_ready);
   endtask

   // Rewrite all four registers while the block is idle; unchanged ones are harmless.
   task automatic program_csrs(input int unsigned enc, input int unsigned count,
                               input int unsigned cols, input int unsigned frames);
      wait_idle();
      write_csr(CSR_ENCODING, enc);
      write_csr(CSR_LED_COUNT, count);
      write_csr(CSR_LED_COLUMNS, cols);
      write_csr(CSR_FRAME_COUNT, frames);
      csr_valid <= 1'b0;
      enc_q    = enc & 32'h3;
      count_q  = count & 32'h7FF;
      cols_q   = cols & 32'h7FF;
      frames_q = frames & 32'hFFFF;
   endtask

   // Reset defaults: rgb24 raw, 64 LEDs in rows of 8, one frame.
   task automatic test_rgb24_raw();
      send_bytes(8'h00, 8'h00, 8'h00);
      send_bytes(8'hFF, 8'hFF, 8'hFF);
      send_bytes(8'hA5, 8'h5A, 8'hC3);
   endtask

   // Full-scale, zero, and the green bits split across both bytes.
   task automatic test_rgb565_raw();
      program_csrs(ENC_565_RAW, 64, 8, 1);
      send_bytes(8'hFF, 8'hFF, 8'h00);
      send_bytes(8'h00, 8'h00, 8'hFF);
      send_bytes(8'h07, 8'hE0, 8'h5A);
   endtask

   // Plain run, zero-length run mid-frame, run clipped at the frame end,
   // then the unused encoding code.
   task automatic test_rle_runs();
      program_csrs(ENC_565_RLE, 64, 8, 1);
      send_bytes(8'd5, 8'hF8, 8'h1F);
      send_bytes(8'd0, 8'h12, 8'h34);
      send_bytes(8'd255, 8'h07, 8'hE0);
      program_csrs(EncUnused, 64, 8, 1);
      send_bytes(8'h81, 8'h42, 8'h24);
   endtask

   // Saturated LED count and zero frame count with single-LED rows push the row toward
   // its top; then zero and oversize columns and a zero LED count.
   task automatic test_geometry_extremes();
      program_csrs(ENC_565_RLE, 2047, 1, 0);
      repeat (5) send_bytes(8'd255, 8'hAA, 8'h55);
      program_csrs(ENC_RGB24, 0, 0, 1);
      send_bytes(8'h11, 8'h22, 8'h33);
      program_csrs(ENC_565_RAW, 64, 2047, 65535);
      send_bytes(8'hC7, 8'h3E, 8'h00);
   endtask

   // Lower the LED count under the current position: a nonzero run is clipped
   // to nothing with overrun; then, set up again, a zero run ends the frame.
   task automatic test_position_past_count();
      program_csrs(ENC_565_RLE, 200, 16, 4);
      send_bytes(8'd255, 8'h00, 8'h00);
      send_bytes(8'd150, 8'h10, 8'h01);
      program_csrs(ENC_565_RLE, 100, 16, 4);
      send_bytes(8'd150, 8'h10, 8'h01);
      program_csrs(ENC_565_RLE, 200, 16, 4);
      send_bytes(8'd150, 8'h10, 8'h01);
      program_csrs(ENC_565_RLE, 100, 16, 4);
      send_bytes(8'd0, 8'h20, 8'h02);
      send_bytes(8'd7, 8'h30, 8'h03);
   endtask

   // Advance the frame number, then lower the frame count beneath it.
   task automatic test_frame_past_count();
      program_csrs(ENC_RGB24, 1, 1, 65535);
      repeat (3) send_bytes(8'h01, 8'h02, 8'h03);
      program_csrs(ENC_RGB24, 1, 1, 2);
      repeat (2) send_bytes(8'hFE, 8'hFD, 8'hFC);
   endtask

   // Segments of random records, each under a fresh random register setting.
   // Run-length mode dominates since it reaches clipping and frame ends fastest.
   task automatic test_random_stream();
      int unsigned enc, count, cols, frames;
      req_type     rec;
      for (int seg = 0; seg < SegmentsPerPhase; seg++) begin
         enc = ($urandom_range(9) < 5) ? ENC_565_RLE : $urandom_range(3);
         case ($urandom_range(6))
            0:       count = 0;
            1:       count = 1;
            2:       count = 2047;
            3:       count = 1024;
            4:       count = $urandom_range(1, 16);
            5:       count = $urandom_range(1, 300);
            default: count = $urandom_range(1, 2047);
         endcase
         case ($urandom_range(4))
            0:       cols = 0;
            1:       cols = 1;
            2:       cols = 2047;
            3:       cols = $urandom_range(1, 40);
            default: cols = $urandom_range(1, 1100);
         endcase
         case ($urandom_range(4))
            0:       frames = 0;
            1:       frames = 65535;
            2:       frames = $urandom_range(1, 8);
            3:       frames = $urandom_range(2, 40);
            default: frames = $urandom_range(0, 65535);
         endcase
         program_csrs(enc, count, cols, frames);
         repeat (SegmentRecords) begin
            rec = req_type'($urandom);
            // Short runs, zero among them, now and then
            if ($urandom_range(7) == 0) rec.byte0 = 8'($urandom_range(3));
            send_record(rec);
         end
      end
   endtask

   initial begin
      reset     <= 1'b1;
      req_valid <= 1'b0;
      req_data  <= '0;
      csr_valid <= 1'b0;
      csr_index <= CSR_ENCODING;
      csr_wdata <= '0;
      errors        = 0;
      req_idle_pct  = 20;
      rsp_stall_pct = 20;
      enc_q    = ENCODING_RST;
      count_q  = LED_COUNT_RST;
      cols_q   = LED_COLUMNS_RST;
      frames_q = FRAME_COUNT_RST;
      led_pos  = 0;
      frame_q  = 0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      test_rgb24_raw();
      test_rgb565_raw();
      test_rle_runs();
      test_geometry_extremes();
      test_position_past_count();
      test_frame_past_count();

      // Receiver-heavy stalls, then sender-heavy idling, then full rate.
      req_idle_pct  = 36;
      rsp_stall_pct = 48;
      test_random_stream();
      req_idle_pct  = 48;
      rsp_stall_pct = 36;
      test_random_stream();
      req_idle_pct  = 0;
      rsp_stall_pct = 0;
      test_random_stream();

      wait_idle();
      if (errors == 0 && expected_runs.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
hdl/lfr_pkg.sv
hdl/lfr_div.sv
hdl/lfr_datapath.sv
hdl/lfr_ctrl.sv
hdl/led_frame_rle_rgb565_decoder.sv
hdl/lfr_checker.sv
tb/sv/tb.sv
